FILE: sv/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// shared types and constants of the integer execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int CSR_IDX_W = 12;

    typedef enum logic [5:0] {
        F_ADD   = 6'd0,  F_SUB   = 6'd1,  F_AND   = 6'd2,  F_OR    = 6'd3,
        F_XOR   = 6'd4,  F_SLL   = 6'd5,  F_SRL   = 6'd6,  F_SRA   = 6'd7,
        F_SLT   = 6'd8,  F_SLTU  = 6'd9,  F_MUL   = 6'd10, F_ADDI  = 6'd11,
        F_SUBI  = 6'd12, F_ANDI  = 6'd13, F_ORI   = 6'd14, F_XORI  = 6'd15,
        F_SLLI  = 6'd16, F_SRLI  = 6'd17, F_SRAI  = 6'd18, F_SLTI  = 6'd19,
        F_SLTIU = 6'd20, F_LW    = 6'd21, F_LH    = 6'd22, F_LB    = 6'd23,
        F_LHU   = 6'd24, F_LBU   = 6'd25, F_SW    = 6'd26, F_SH    = 6'd27,
        F_SB    = 6'd28, F_BEQ   = 6'd29, F_BNE   = 6'd30, F_BLT   = 6'd31,
        F_BGE   = 6'd32, F_BLTU  = 6'd33, F_BGEU  = 6'd34, F_JAL   = 6'd35,
        F_JALR  = 6'd36, F_LUI   = 6'd37, F_AUIPC = 6'd38, F_FENCE = 6'd39,
        F_CSRRW = 6'd40, F_CSRRS = 6'd41, F_CSRRC = 6'd42
    } t_func;

    typedef struct packed {
        logic wr;
        logic is_load;
        logic is_store;
        logic is_csr;
        logic use_imm;
    } t_cls;

    typedef struct packed {
        t_func                 op;
        t_cls                  cls;
        logic [4:0]            rd;
        logic [4:0]            rs1;
        logic [4:0]            rs2;
        logic [31:0]           imm;
        logic [31:0]           pc;
        logic [CSR_IDX_W-1:0]  csr;
    } t_item;

endpackage

FILE: sv/rvx_if.sv
// ----------------------------------------------------------------------------
// rvx_in_if / rvx_out_if
// valid-ready channels for decoded instructions and their results
// ----------------------------------------------------------------------------
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  func;
    logic [4:0]  dest_index;
    logic [4:0]  first_source;
    logic [4:0]  second_source;
    logic [31:0] immediate;
    logic [31:0] instr_pc;
    logic [3:0]  csr_select;

    modport source (output valid, func, dest_index, first_source, second_source,
                    immediate, instr_pc, csr_select, input ready);
    modport sink   (input valid, func, dest_index, first_source, second_source,
                    immediate, instr_pc, csr_select, output ready);
endinterface

interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
    logic        store_done;
    logic [31:0] access_address;

    modport source (output valid, next_pc, reg_written, written_index, written_value,
                    store_done, access_address, input ready);
    modport sink   (input valid, next_pc, reg_written, written_index, written_value,
                    store_done, access_address, output ready);
endinterface

FILE: sv/rv32i_integer_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_unit_core
// rv32i execute unit: a front queue of classified instructions feeding an
// operand, execute and memory pipeline with forwarding
// ----------------------------------------------------------------------------
// One instruction per cycle sustained, dependent or not, while the result
// side does not stall; an instruction passes through a queue slot, then the
// operand/execute stage, and its result is offered from the memory stage,
// which is the result register. Register, csr and data store reads come from
// registered ram ports, with the last committed writes forwarded. After reset
// a clearing pass zeroes the register and csr files; no instruction is taken
// meanwhile.
module rv32i_integer_execute_unit_core import rvx_pkg::*; #(
    parameter int DATA_WORDS = 1024,
    parameter int CSR_COUNT  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rvx_in_if.sink     i_in,
    rvx_out_if.source  o_out
);
    logic  w_busy;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;

    rvx_front #(.CSR_COUNT(CSR_COUNT)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_busy   (w_busy),
        .i_pop    (w_pop),
        .o_q_valid(w_q_valid),
        .o_q_item (w_q_item)
    );

    rvx_back #(.DATA_WORDS(DATA_WORDS), .CSR_COUNT(CSR_COUNT)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_pop    (w_pop),
        .o_busy   (w_busy),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_no_transfer_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !(i_in.valid && i_in.ready))
        else $error("transfer in during clearing pass");

    a_no_write_to_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.reg_written) |-> (o_out.written_index != 5'd0))
        else $error("write reported to x0");

    a_store_no_reg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.store_done) |-> !o_out.reg_written)
        else $error("store also wrote a register");
`endif
endmodule

FILE: sv/rvx_ram.sv
// ----------------------------------------------------------------------------
// rvx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: sv/rvx_front.sv
// ----------------------------------------------------------------------------
// rvx_front
// accepts and classifies instructions into a two entry queue
// ----------------------------------------------------------------------------
module rvx_front import rvx_pkg::*; #(
    parameter int CSR_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvx_in_if.sink    i_in,
    input  logic      i_busy,
    input  logic      i_pop,
    output logic      o_q_valid,
    output t_item     o_q_item
);
    logic [CSR_IDX_W-1:0] w_csr_tbl [16];
    t_item                w_item;
    t_func                w_op;
    t_item                r_q [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push;

    // csr index reduction, residues worked out at elaboration
    for (genvar g = 0; g < 16; g++) begin : g_csr
        localparam int RES = g % CSR_COUNT;
        assign w_csr_tbl[g] = CSR_IDX_W'(RES);
    end

    assign w_op = t_func'(i_in.func);

    always_comb begin
        w_item      = '0;
        w_item.op   = w_op;
        w_item.rd   = i_in.dest_index;
        w_item.rs1  = i_in.first_source;
        w_item.rs2  = i_in.second_source;
        w_item.imm  = i_in.immediate;
        w_item.pc   = i_in.instr_pc;
        w_item.csr  = w_csr_tbl[i_in.csr_select];
        unique case (w_op) inside
            F_ADD, F_SUB, F_AND, F_OR, F_XOR, F_SLL, F_SRL, F_SRA, F_SLT, F_SLTU,
            F_MUL, F_JAL, F_JALR, F_LUI, F_AUIPC: begin
                w_item.cls.wr = 1'b1;
            end
            F_ADDI, F_SUBI, F_ANDI, F_ORI, F_XORI, F_SLLI, F_SRLI, F_SRAI, F_SLTI,
            F_SLTIU: begin
                w_item.cls.wr      = 1'b1;
                w_item.cls.use_imm = 1'b1;
            end
            F_LW, F_LH, F_LB, F_LHU, F_LBU: begin
                w_item.cls.wr      = 1'b1;
                w_item.cls.is_load = 1'b1;
            end
            F_SW, F_SH, F_SB: begin
                w_item.cls.is_store = 1'b1;
            end
            F_CSRRW, F_CSRRS, F_CSRRC: begin
                w_item.cls.wr     = 1'b1;
                w_item.cls.is_csr = 1'b1;
            end
            default: begin
                w_item.cls = '0;
            end
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2) && !i_busy;
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule

FILE: sv/rvx_back.sv
// ----------------------------------------------------------------------------
// rvx_back
// operand read, execute and memory stages with the result register
// ----------------------------------------------------------------------------
module rvx_back import rvx_pkg::*; #(
    parameter int DATA_WORDS = 1024,
    parameter int CSR_COUNT  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_pop,
    output logic       o_busy,
    rvx_out_if.source  o_out
);
    localparam int SW     = $clog2(DATA_WORDS > 1 ? DATA_WORDS : 2);
    localparam int CAW    = $clog2(CSR_COUNT > 1 ? CSR_COUNT : 2);
    localparam int CLR_N  = CSR_COUNT > 32 ? CSR_COUNT : 32;
    localparam int CLR_W  = $clog2(CLR_N) + 1;

    // clearing pass
    logic               r_clearing;
    logic [CLR_W-1:0]   r_clr_cnt;

    // stage b
    logic               r_b_valid;
    t_item              r_b_item;
    // stage c
    logic               r_c_valid;
    t_func              r_c_op;
    logic               r_c_wr;
    logic [4:0]         r_c_rd;
    logic [31:0]        r_c_val;
    logic [31:0]        r_c_npc;
    logic [31:0]        r_c_acc;
    logic [SW-1:0]      r_c_slot;
    logic [31:0]        r_c_bdata;
    logic               r_c_load;
    logic               r_c_store;
    logic               r_c_csr;
    logic [CAW-1:0]     r_c_csr_idx;
    logic [31:0]        r_c_csr_new;
    // last committed writes
    logic               r_w_valid;
    logic [4:0]         r_w_rd;
    logic [31:0]        r_w_val;
    logic               r_wc_valid;
    logic [CAW-1:0]     r_wc_idx;
    logic [31:0]        r_wc_val;
    logic               r_ws_valid;
    logic [SW-1:0]      r_ws_slot;
    logic [31:0]        r_ws_data;

    logic               w_adv;
    logic               w_commit;
    logic [31:0]        w_rf1;
    logic [31:0]        w_rf2;
    logic [31:0]        w_csr_rd;
    logic [31:0]        w_dm_rd;
    logic               w_rf_we;
    logic [4:0]         w_rf_waddr;
    logic [31:0]        w_rf_wdata;
    logic               w_csr_we;
    logic [CAW-1:0]     w_csr_waddr;
    logic [31:0]        w_csr_wdata;
    logic [CAW-1:0]     w_b_csr_idx;
    logic [31:0]        w_a;
    logic [31:0]        w_b;
    logic [31:0]        w_old;
    logic [31:0]        w_opb;
    logic [31:0]        w_addr;
    logic [31:0]        w_mul;
    logic [SW-1:0]      w_tbl [4][256];
    logic [SW+1:0]      w_sum;
    logic [SW+1:0]      w_red;
    logic [SW-1:0]      w_slot;
    logic [31:0]        w_val;
    logic [31:0]        w_npc;
    logic               w_wr;
    logic [31:0]        w_csr_new;
    logic               w_taken;
    logic [31:0]        w_word;
    logic [31:0]        w_ld;
    logic [31:0]        w_st;
    logic [31:0]        w_c_value;

    assign w_adv    = !r_c_valid || o_out.ready;
    assign w_commit = r_c_valid && o_out.ready;
    assign o_pop    = w_adv && i_q_valid && !r_clearing;
    assign o_busy   = r_clearing;

    // register and csr files, cleared after reset
    assign w_rf_we     = r_clearing ? (r_clr_cnt < CLR_W'(32)) : (w_commit && r_c_wr);
    assign w_rf_waddr  = r_clearing ? r_clr_cnt[4:0] : r_c_rd;
    assign w_rf_wdata  = r_clearing ? 32'd0 : w_c_value;
    assign w_csr_we    = r_clearing ? (r_clr_cnt < CLR_W'(CSR_COUNT)) : (w_commit && r_c_csr);
    assign w_csr_waddr = r_clearing ? r_clr_cnt[CAW-1:0] : r_c_csr_idx;
    assign w_csr_wdata = r_clearing ? 32'd0 : r_c_csr_new;

    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk(i_clk), .i_we(w_rf_we), .i_waddr(w_rf_waddr), .i_wdata(w_rf_wdata),
        .i_re(w_adv), .i_raddr(i_q_item.rs1), .o_rdata(w_rf1)
    );
    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk(i_clk), .i_we(w_rf_we), .i_waddr(w_rf_waddr), .i_wdata(w_rf_wdata),
        .i_re(w_adv), .i_raddr(i_q_item.rs2), .o_rdata(w_rf2)
    );
    rvx_ram #(.WIDTH(32), .DEPTH(CSR_COUNT)) u_csr (
        .i_clk(i_clk), .i_we(w_csr_we), .i_waddr(w_csr_waddr), .i_wdata(w_csr_wdata),
        .i_re(w_adv), .i_raddr(i_q_item.csr[CAW-1:0]), .o_rdata(w_csr_rd)
    );
    rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(w_commit && r_c_store), .i_waddr(r_c_slot), .i_wdata(w_st),
        .i_re(w_adv), .i_raddr(w_slot), .o_rdata(w_dm_rd)
    );

    // operand forwarding
    assign w_b_csr_idx = r_b_item.csr[CAW-1:0];

    always_comb begin
        if (r_b_item.rs1 == 5'd0) begin
            w_a = 32'd0;
        end else if (r_c_valid && r_c_wr && r_c_rd == r_b_item.rs1) begin
            w_a = w_c_value;
        end else if (r_w_valid && r_w_rd == r_b_item.rs1) begin
            w_a = r_w_val;
        end else begin
            w_a = w_rf1;
        end
        if (r_b_item.rs2 == 5'd0) begin
            w_b = 32'd0;
        end else if (r_c_valid && r_c_wr && r_c_rd == r_b_item.rs2) begin
            w_b = w_c_value;
        end else if (r_w_valid && r_w_rd == r_b_item.rs2) begin
            w_b = r_w_val;
        end else begin
            w_b = w_rf2;
        end
        if (r_c_valid && r_c_csr && r_c_csr_idx == w_b_csr_idx) begin
            w_old = r_c_csr_new;
        end else if (r_wc_valid && r_wc_idx == w_b_csr_idx) begin
            w_old = r_wc_val;
        end else begin
            w_old = w_csr_rd;
        end
    end

    assign w_opb  = r_b_item.cls.use_imm ? r_b_item.imm : w_b;
    assign w_addr = w_a + r_b_item.imm;
    assign w_mul  = w_a * w_b;

    // word slot: residues of address bytes summed, then reduced below DATA_WORDS
    for (genvar k = 0; k < 4; k++) begin : g_k
        for (genvar g = 0; g < 256; g++) begin : g_e
            localparam logic [63:0] RES = (64'(g) << (8 * k)) % 64'(DATA_WORDS);
            assign w_tbl[k][g] = SW'(RES);
        end
    end

    always_comb begin
        w_sum = (SW+2)'(w_tbl[0][w_addr[9:2]]) + (SW+2)'(w_tbl[1][w_addr[17:10]])
              + (SW+2)'(w_tbl[2][w_addr[25:18]]) + (SW+2)'(w_tbl[3][{2'b00, w_addr[31:26]}]);
        w_red = (w_sum >= (SW+2)'(2 * DATA_WORDS)) ? w_sum - (SW+2)'(2 * DATA_WORDS) : w_sum;
        w_red = (w_red >= (SW+2)'(DATA_WORDS)) ? w_red - (SW+2)'(DATA_WORDS) : w_red;
        w_slot = w_red[SW-1:0];
    end

    // execute
    always_comb begin
        w_val     = 32'd0;
        w_npc     = r_b_item.pc + 32'd4;
        w_wr      = r_b_item.cls.wr && (r_b_item.rd != 5'd0);
        w_csr_new = w_old;
        w_taken   = 1'b0;
        case (r_b_item.op)
            F_ADD, F_ADDI:   w_val = w_a + w_opb;
            F_SUB, F_SUBI:   w_val = w_a - w_opb;
            F_AND, F_ANDI:   w_val = w_a & w_opb;
            F_OR, F_ORI:     w_val = w_a | w_opb;
            F_XOR, F_XORI:   w_val = w_a ^ w_opb;
            F_SLL, F_SLLI:   w_val = w_a << w_opb[4:0];
            F_SRL, F_SRLI:   w_val = w_a >> w_opb[4:0];
            F_SRA, F_SRAI:   w_val = 32'($signed(w_a) >>> w_opb[4:0]);
            F_SLT, F_SLTI:   w_val = {31'd0, $signed(w_a) < $signed(w_opb)};
            F_SLTU, F_SLTIU: w_val = {31'd0, w_a < w_opb};
            F_MUL:           w_val = w_mul;
            F_BEQ:           w_taken = (w_a == w_b);
            F_BNE:           w_taken = (w_a != w_b);
            F_BLT:           w_taken = $signed(w_a) < $signed(w_b);
            F_BGE:           w_taken = !($signed(w_a) < $signed(w_b));
            F_BLTU:          w_taken = (w_a < w_b);
            F_BGEU:          w_taken = (w_a >= w_b);
            F_JAL: begin
                if (r_b_item.rd == 5'd0 && r_b_item.imm == 32'd0) begin
                    w_npc = 32'd0;
                    w_wr  = 1'b0;
                end else begin
                    w_val = r_b_item.pc + 32'd4;
                    w_npc = r_b_item.pc + r_b_item.imm;
                end
            end
            F_JALR: begin
                w_val = r_b_item.pc + 32'd4;
                w_npc = {w_addr[31:1], 1'b0};
            end
            F_LUI:   w_val = {r_b_item.imm[19:0], 12'd0};
            F_AUIPC: w_val = r_b_item.pc + {r_b_item.imm[19:0], 12'd0};
            F_CSRRW: begin
                w_val     = w_old;
                w_csr_new = w_a;
            end
            F_CSRRS: begin
                w_val     = w_old;
                w_csr_new = w_old | w_a;
            end
            F_CSRRC: begin
                w_val     = w_old;
                w_csr_new = w_old & ~w_a;
            end
            default: w_val = 32'd0;
        endcase
        if (w_taken) begin
            w_npc = r_b_item.pc + r_b_item.imm;
        end
        if (!w_wr) begin
            w_val = 32'd0;
        end
    end

    // memory stage, with the last store forwarded over the ram read
    assign w_word = (r_ws_valid && r_ws_slot == r_c_slot) ? r_ws_data : w_dm_rd;

    always_comb begin
        case (r_c_op)
            F_LH:    w_ld = {{16{w_word[15]}}, w_word[15:0]};
            F_LB:    w_ld = {{24{w_word[7]}}, w_word[7:0]};
            F_LHU:   w_ld = {16'd0, w_word[15:0]};
            F_LBU:   w_ld = {24'd0, w_word[7:0]};
            default: w_ld = w_word;
        endcase
        case (r_c_op)
            F_SH:    w_st = {w_word[31:16], r_c_bdata[15:0]};
            F_SB:    w_st = {w_word[31:8], r_c_bdata[7:0]};
            default: w_st = r_c_bdata;
        endcase
    end

    assign w_c_value = r_c_load ? (r_c_wr ? w_ld : 32'd0) : r_c_val;

    assign o_out.valid          = r_c_valid;
    assign o_out.next_pc        = r_c_npc;
    assign o_out.reg_written    = r_c_wr;
    assign o_out.written_index  = r_c_rd;
    assign o_out.written_value  = w_c_value;
    assign o_out.store_done     = r_c_store;
    assign o_out.access_address = r_c_acc;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_item    <= i_q_item;
            r_c_op      <= r_b_item.op;
            r_c_wr      <= w_wr;
            r_c_rd      <= w_wr ? r_b_item.rd : 5'd0;
            r_c_val     <= w_val;
            r_c_npc     <= w_npc;
            r_c_acc     <= (r_b_item.cls.is_load || r_b_item.cls.is_store) ? w_addr : 32'd0;
            r_c_slot    <= w_slot;
            r_c_bdata   <= w_b;
            r_c_load    <= r_b_item.cls.is_load;
            r_c_store   <= r_b_item.cls.is_store;
            r_c_csr     <= r_b_item.cls.is_csr;
            r_c_csr_idx <= w_b_csr_idx;
            r_c_csr_new <= w_csr_new;
        end
        if (w_commit) begin
            if (r_c_wr) begin
                r_w_rd  <= r_c_rd;
                r_w_val <= w_c_value;
            end
            if (r_c_csr) begin
                r_wc_idx <= r_c_csr_idx;
                r_wc_val <= r_c_csr_new;
            end
            if (r_c_store) begin
                r_ws_slot <= r_c_slot;
                r_ws_data <= w_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_w_valid  <= 1'b0;
            r_wc_valid <= 1'b0;
            r_ws_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
                if (r_clr_cnt == CLR_W'(CLR_N - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_adv) begin
                r_b_valid <= o_pop;
                r_c_valid <= r_b_valid;
            end
            if (w_commit && r_c_wr) begin
                r_w_valid <= 1'b1;
            end
            if (w_commit && r_c_csr) begin
                r_wc_valid <= 1'b1;
            end
            if (w_commit && r_c_store) begin
                r_ws_valid <= 1'b1;
            end
        end
    end
endmodule
